// File: rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// shared types, token codes, keyword table and byte class helpers for the
// source byte tokenizer
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int unsigned SOURCE_BYTES = 65536;
	localparam logic [15:0] POS_LIMIT    = (SOURCE_BYTES < 65535) ? 16'(SOURCE_BYTES) : 16'hFFFF;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// token codes
	localparam logic [4:0] KIND_COMMA   = 5'd0;
	localparam logic [4:0] KIND_SEMI    = 5'd1;
	localparam logic [4:0] KIND_LPAREN  = 5'd2;
	localparam logic [4:0] KIND_RPAREN  = 5'd3;
	localparam logic [4:0] KIND_LBRACE  = 5'd4;
	localparam logic [4:0] KIND_RBRACE  = 5'd5;
	localparam logic [4:0] KIND_PLUS    = 5'd6;
	localparam logic [4:0] KIND_MINUS   = 5'd7;
	localparam logic [4:0] KIND_STAR    = 5'd8;
	localparam logic [4:0] KIND_SLASH   = 5'd9;
	localparam logic [4:0] KIND_EQ      = 5'd10;
	localparam logic [4:0] KIND_EQEQ    = 5'd11;
	localparam logic [4:0] KIND_BANG    = 5'd12;
	localparam logic [4:0] KIND_BANGEQ  = 5'd13;
	localparam logic [4:0] KIND_KW0     = 5'd14;
	localparam logic [4:0] KIND_IDENT   = 5'd24;
	localparam logic [4:0] KIND_STRING  = 5'd25;
	localparam logic [4:0] KIND_NUMBER  = 5'd26;
	localparam logic [4:0] KIND_EOF     = 5'd27;
	localparam logic [4:0] KIND_ERR_NUM = 5'd28;
	localparam logic [4:0] KIND_ERR_STR = 5'd29;
	localparam logic [4:0] KIND_ERR_OVF = 5'd30;

	// character codes
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BANG      = 8'h21;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_SEMI      = 8'h3B;

	localparam int unsigned KW_COUNT = 10;

	// keyword text, first byte in bits 7:0, zero padded
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'h000065757274, // true
		48'h0065736c6166, // false
		48'h000000006669, // if
		48'h000065736c65, // else
		48'h000000726f66, // for
		48'h6e7275746572, // return
		48'h0000636e7566, // func
		48'h00746e697270, // print
		48'h000000646e61, // and
		48'h00000000726f  // or
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd4, 3'd5, 3'd2, 3'd4, 3'd3, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2
	};

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_IDENT  = 8'b0000_0010,
		PH_NUMBER = 8'b0000_0100,
		PH_STRING = 8'b0000_1000,
		PH_ESCAPE = 8'b0001_0000,
		PH_BANG   = 8'b0010_0000,
		PH_EQUAL  = 8'b0100_0000,
		PH_HALT   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
	} tok_t;

	// tokens caused by one input beat, tok[0] first
	typedef struct packed {
		tok_t [2:0] tok;
		logic [1:0] cnt;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_ws(logic [7:0] b);
		return b == 8'h20 || b == 8'h0A || b == 8'h0D || b == 8'h09;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F};
	endfunction

	function automatic logic is_single(logic [7:0] b);
		return b inside {8'h2C, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2B, 8'h2D, 8'h2A, 8'h2F};
	endfunction

	function automatic logic [4:0] single_kind(logic [7:0] b);
		logic [4:0] k;
		case (b)
			8'h2C:   k = KIND_COMMA;
			8'h3B:   k = KIND_SEMI;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			8'h2B:   k = KIND_PLUS;
			8'h2D:   k = KIND_MINUS;
			8'h2A:   k = KIND_STAR;
			default: k = KIND_SLASH;
		endcase
		return k;
	endfunction

	// unused tail bytes of the chars are zero, so a whole-word compare works
	function automatic logic [4:0] ident_kind(logic [47:0] chars, logic [15:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (len == {13'd0, KW_LEN[i]} && chars == KW_TEXT[i])
				k = KIND_KW0 + 5'(i);
		end
		return k;
	endfunction

	function automatic bundle_t push_tok(bundle_t b, logic [4:0] k, logic [15:0] o,
		logic [15:0] l);
		bundle_t r;
		r = b;
		if (b.cnt != 2'd3) begin
			r.tok[b.cnt] = '{kind: k, offset: o, length: l};
			r.cnt        = b.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

// File: rtl/sbt_if.sv
// ----------------------------------------------------------------------------
// sbt_if
// valid/ready channels of the tokenizer: source bytes in, tokens out
// ----------------------------------------------------------------------------
interface sbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_source;

	modport source (output valid, source_byte, end_of_source, input ready);
	modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface sbt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_offset;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, token_kind, token_offset, token_length, last_of_run,
		input ready);
	modport sink (input valid, token_kind, token_offset, token_length, last_of_run,
		output ready);
endinterface

// File: rtl/sbt_front.sv
// ----------------------------------------------------------------------------
// sbt_front
// accepts source bytes, runs the lexer state and builds the bundle of up to
// three tokens each byte causes
// ----------------------------------------------------------------------------
module sbt_front (
	input  logic            clk,
	input  logic            arst_n,
	sbt_byte_if.sink        src,
	input  sbt_pkg::qstat_t qstat,
	output logic            push,
	output sbt_pkg::bundle_t push_data
);
	import sbt_pkg::*;

	phase_t      phase_q;
	logic [15:0] pos_q;
	logic [15:0] begin_q;
	logic [47:0] kw_q;

	phase_t      ph;
	logic [15:0] tb;
	logic [47:0] kwc;
	bundle_t     bun;
	logic        again;
	logic [15:0] p;
	logic [15:0] stop;
	logic [15:0] idx;
	logic [7:0]  b;
	logic        last;
	logic        accept;

	assign src.ready = !qstat.full;
	assign accept    = src.valid && src.ready;

	always_comb begin
		b     = src.source_byte;
		last  = src.end_of_source;
		p     = pos_q;
		stop  = pos_q + 16'd1;
		idx   = pos_q - begin_q;
		ph    = phase_q;
		tb    = begin_q;
		kwc   = kw_q;
		bun   = '0;
		again = 1'b0;

		if (ph != PH_HALT && p >= POS_LIMIT) begin
			bun = push_tok(bun, KIND_ERR_OVF, POS_LIMIT, 16'd0);
			ph  = PH_HALT;
		end else if (ph != PH_HALT) begin
			case (ph)
				PH_IDENT: begin
					if (is_word(b)) begin
						if (idx < 16'd6)
							kwc[{idx[2:0], 3'b000} +: 8] = b;
					end else begin
						bun   = push_tok(bun, ident_kind(kwc, p - tb), tb, p - tb);
						ph    = PH_IDLE;
						again = 1'b1;
					end
				end
				PH_NUMBER: begin
					if (!is_digit(b)) begin
						if (is_ws(b) || b == CH_SEMI) begin
							bun   = push_tok(bun, KIND_NUMBER, tb, p - tb);
							ph    = PH_IDLE;
							again = 1'b1;
						end else begin
							bun = push_tok(bun, KIND_ERR_NUM, tb, p - tb);
							ph  = PH_HALT;
						end
					end
				end
				PH_STRING: begin
					if (b == CH_BACKSLASH) begin
						ph = PH_ESCAPE;
					end else if (b == CH_QUOTE) begin
						bun = push_tok(bun, KIND_STRING, tb + 16'd1, p - tb - 16'd1);
						ph  = PH_IDLE;
					end
				end
				PH_ESCAPE: begin
					ph = PH_STRING;
				end
				PH_BANG, PH_EQUAL: begin
					if (b == CH_EQUAL) begin
						bun = push_tok(bun, (ph == PH_BANG) ? KIND_BANGEQ : KIND_EQEQ, tb,
							16'd2);
					end else begin
						bun   = push_tok(bun, (ph == PH_BANG) ? KIND_BANG : KIND_EQ, tb,
							16'd1);
						again = 1'b1;
					end
					ph = PH_IDLE;
				end
				default: begin
					again = 1'b1;
				end
			endcase

			// byte opens a new token
			if (again && !is_ws(b)) begin
				if (b == CH_NUL) begin
					bun = push_tok(bun, KIND_EOF, p, 16'd0);
					ph  = PH_HALT;
				end else if (is_single(b)) begin
					bun = push_tok(bun, single_kind(b), p, 16'd1);
				end else begin
					tb = p;
					if (b == CH_BANG) begin
						ph = PH_BANG;
					end else if (b == CH_EQUAL) begin
						ph = PH_EQUAL;
					end else if (is_digit(b)) begin
						ph = PH_NUMBER;
					end else if (b == CH_QUOTE) begin
						ph = PH_STRING;
					end else begin
						ph  = PH_IDENT;
						kwc = {40'd0, b};
					end
				end
			end

			// end of source closes the pending token
			if (last && ph != PH_HALT) begin
				case (ph)
					PH_IDENT:  bun = push_tok(bun, ident_kind(kwc, stop - tb), tb, stop - tb);
					PH_NUMBER: bun = push_tok(bun, KIND_NUMBER, tb, stop - tb);
					PH_BANG:   bun = push_tok(bun, KIND_BANG, tb, 16'd1);
					PH_EQUAL:  bun = push_tok(bun, KIND_EQ, tb, 16'd1);
					default: ;
				endcase
				if (ph == PH_STRING || ph == PH_ESCAPE) begin
					bun = push_tok(bun, KIND_ERR_STR, tb + 16'd1, stop - tb - 16'd1);
				end else begin
					bun = push_tok(bun, KIND_EOF, stop, 16'd0);
				end
			end
		end
	end

	assign push      = accept && bun.cnt != 2'd0;
	assign push_data = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			kw_q    <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_IDLE;
				pos_q   <= '0;
				begin_q <= '0;
				kw_q    <= '0;
			end else begin
				phase_q <= ph;
				pos_q   <= (pos_q != 16'hFFFF) ? stop : pos_q;
				begin_q <= tb;
				kw_q    <= kwc;
			end
		end
	end

endmodule

// File: rtl/sbt_queue.sv
// ----------------------------------------------------------------------------
// sbt_queue
// short register queue of token bundles between front and back
// ----------------------------------------------------------------------------
module sbt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbt_pkg::bundle_t push_data,
	input  logic             pop,
	output sbt_pkg::bundle_t head,
	output sbt_pkg::qstat_t  qstat
);
	import sbt_pkg::*;

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/sbt_back.sv
// ----------------------------------------------------------------------------
// sbt_back
// walks the head bundle one token per beat and marks the last of the run
// ----------------------------------------------------------------------------
module sbt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sbt_pkg::bundle_t head,
	input  sbt_pkg::qstat_t  qstat,
	output logic             pop,
	sbt_token_if.source      tok
);
	import sbt_pkg::*;

	logic [1:0] sub_q;
	logic       is_last;
	tok_t       cur;

	assign cur     = head.tok[sub_q];
	assign is_last = sub_q == head.cnt - 2'd1;

	assign tok.valid        = !qstat.empty;
	assign tok.token_kind   = cur.kind;
	assign tok.token_offset = cur.offset;
	assign tok.token_length = cur.length;
	assign tok.last_of_run  = is_last;

	assign pop = tok.valid && tok.ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (tok.valid && tok.ready) begin
			sub_q <= is_last ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

// File: rtl/source_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top
// streaming lexer: source bytes in, (kind, offset, length) tokens out
//
//   port   dir   beat contents
//   src    sink  source_byte, end_of_source
//   tok    src   token_kind, token_offset, token_length, last_of_run
//
// one source byte per cycle while the bundle queue has room; the front
// updates lexer state in the cycle the byte is taken
// tokens leave one per cycle while tok is ready; a byte causing k tokens holds the back until
// all k have left, so throughput is limited by the token rate through the queue
// reset returns to the idle state at offset zero, queue empty
// tok stalls fill the four-bundle queue, then src.ready drops
// ----------------------------------------------------------------------------
module source_byte_tokenizer_top (
	input logic         clk,
	input logic         arst_n,
	sbt_byte_if.sink    src,
	sbt_token_if.source tok
);
	import sbt_pkg::*;

	logic    push;
	bundle_t push_data;
	logic    pop;
	bundle_t head;
	qstat_t  qstat;

	sbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (src),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	sbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	sbt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tok    (tok)
	);

	a_empty_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !tok.valid)
		else $error("token offered from empty queue");

	a_full_blocks_src: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !src.ready)
		else $error("byte taken while queue full");

	a_eof_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.token_kind == KIND_EOF |-> tok.token_length == 16'd0)
		else $error("eof token with nonzero length");

	a_ovf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.token_kind == KIND_ERR_OVF |->
			tok.token_offset == POS_LIMIT && tok.token_length == 16'd0 && tok.last_of_run)
		else $error("malformed overflow token");

endmodule
